### src/kmp_first_match_finder_macros.svh
// Assertion macros for the first-match finder checker.
// Clock aclk and reset aresetn must be visible where a macro is used.
`ifndef KMP_FIRST_MATCH_FINDER_MACROS_SVH
`define KMP_FIRST_MATCH_FINDER_MACROS_SVH

// antecedent implies consequent in the next cycle, disabled in reset
`define KFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle, disabled in reset
`define KFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// checked through reset as well
`define KFM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

### src/kfm_pkg.sv
// Shared constants and helpers for the KMP first-match finder.
// No dependencies; used by the top level and its checker.
package kfm_pkg;

    localparam int TEXT_BYTE_W   = 8;
    localparam int MATCH_START_W = 12;
    localparam int PAT_REG_W     = 64;
    localparam int PLEN_W        = 5;
    localparam int PAT_IDX_W     = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    // pattern byte lookup; bytes at index 16 and above read as zero
    function automatic logic [TEXT_BYTE_W-1:0] pat_byte(
        input logic [2*PAT_REG_W-1:0] pat,
        input logic [PAT_IDX_W-1:0]   idx
    );
        logic [TEXT_BYTE_W-1:0] b;
        b = pat[idx[3:0]*TEXT_BYTE_W +: TEXT_BYTE_W];
        if (idx[4]) begin
            b = '0;
        end
        return b;
    endfunction

endpackage

### src/kmp_first_match_finder.sv
// KMP first-match finder: top level, sequencer and failure table.
// Depends on kfm_pkg.
//
// Text bytes stream in one word at a time; the block answers once per text
// with the start of the first full match, or found = 0 at the word marked
// last. The failure table is rebuilt at the first word of each text. One
// table read port serves both the table build and the text walk, under a
// small sequencer; the build and the walk each have their own byte comparator.
// A text word passes ST_IDLE, ST_MATCH (again per failure-chain step on a
// mismatch) and ST_FINISH; the first word of a text first runs ST_BUILD over
// the effective pattern length (0 counts as 1, above PATTERN_MAX as
// PATTERN_MAX), plus its chain steps. Words after the text is answered, or
// past TEXT_MAX, go from ST_IDLE to ST_FINISH. A result waits in an output
// register; the next word is accepted meanwhile. A word that produces a result
// while the previous one still waits stays in ST_FINISH until that one is taken.
module kmp_first_match_finder #(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [kfm_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [kfm_pkg::PAT_REG_W-1:0]        cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [kfm_pkg::S_TDATA_W-1:0]        s_tdata,   // [7:0] text_byte
    input  logic                                 s_tlast,   // text_last
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [kfm_pkg::M_TDATA_W-1:0]        m_tdata,   // [11:0] match_start
    output logic [0:0]                           m_tuser    // [0] found
);
    import kfm_pkg::*;

    localparam int NW = $clog2(PATTERN_MAX + 1);
    localparam int FW = $clog2(PATTERN_MAX);
    localparam int PW = $clog2(TEXT_MAX + 1);
    localparam int SW = (PW > MATCH_START_W) ? PW : MATCH_START_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_MATCH,
        ST_FINISH
    } state_t;

    state_t                     state_reg;
    logic [PAT_REG_W-1:0]       pat_low_reg;
    logic [PAT_REG_W-1:0]       pat_high_reg;
    logic [PLEN_W-1:0]          plen_reg;
    logic [FW-1:0]              q_reg;
    logic [PW-1:0]              pos_reg;
    logic                       rep_reg;
    logic [FW-1:0]              i_reg;
    logic [FW-1:0]              k_reg;
    logic [TEXT_BYTE_W-1:0]     c_reg;
    logic                       last_reg;
    logic                       found_reg;
    logic [MATCH_START_W-1:0]   start_reg;
    logic                       m_valid_reg;
    logic                       m_found_reg;
    logic [MATCH_START_W-1:0]   m_start_reg;

    logic [FW-1:0]              tbl_mem [PATTERN_MAX];

    logic [2*PAT_REG_W-1:0]     pat;
    logic [NW-1:0]              n_cur;
    logic [NW-1:0]              n_new;
    logic [PLEN_W-1:0]          plen_next;
    logic [FW-1:0]              rd_addr;
    logic [FW-1:0]              tbl_rd;
    logic                       eq_b;
    logic                       eq_m;
    logic [FW-1:0]              k_next;
    logic [NW-1:0]              q_next;
    logic [NW-1:0]              i_inc;
    logic [SW-1:0]              start_full;
    logic                       pend;
    logic                       out_busy;
    logic                       accept;
    logic                       tbl_we;
    logic [FW-1:0]              tbl_wa;
    logic [FW-1:0]              tbl_wd;

    function automatic logic [NW-1:0] clamp_len(input logic [PLEN_W-1:0] len);
        logic [NW-1:0] n;
        if (len == '0) begin
            n = NW'(1);
        end else if (int'(len) > PATTERN_MAX) begin
            n = NW'(PATTERN_MAX);
        end else begin
            n = NW'(len);
        end
        return n;
    endfunction

    assign pat       = {pat_high_reg, pat_low_reg};
    assign n_cur     = clamp_len(plen_reg);
    assign plen_next = (cfg_addr == CFG_PATTERN_LENGTH) ? cfg_wdata[PLEN_W-1:0] : plen_reg;
    assign n_new     = clamp_len(plen_next);

    assign rd_addr = ((state_reg == ST_MATCH) ? q_reg : k_reg) - FW'(1);
    assign tbl_rd  = tbl_mem[rd_addr];

    assign eq_b   = pat_byte(pat, PAT_IDX_W'(i_reg)) == pat_byte(pat, PAT_IDX_W'(k_reg));
    assign eq_m   = pat_byte(pat, PAT_IDX_W'(q_reg)) == c_reg;
    assign k_next = k_reg + FW'(eq_b);
    assign q_next = NW'(q_reg) + NW'(eq_m);
    assign i_inc  = NW'(i_reg) + NW'(1);

    assign start_full = SW'(pos_reg) + SW'(1) - SW'(n_cur);

    assign accept   = s_tvalid && s_tready;
    assign pend     = found_reg || (last_reg && !rep_reg);
    assign out_busy = m_valid_reg && !m_tready;

    always_comb begin
        tbl_we = 1'b0;
        tbl_wa = '0;
        tbl_wd = '0;
        if (state_reg == ST_IDLE && accept && pos_reg == '0 && !rep_reg) begin
            tbl_we = 1'b1;
        end else if (state_reg == ST_BUILD && !(k_reg != '0 && !eq_b)) begin
            tbl_we = 1'b1;
            tbl_wa = i_reg;
            tbl_wd = k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            plen_reg     <= PLEN_W'(1);
            q_reg        <= '0;
            pos_reg      <= '0;
            rep_reg      <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !(state_reg == ST_FINISH && pend)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        c_reg     <= s_tdata[TEXT_BYTE_W-1:0];
                        last_reg  <= s_tlast;
                        found_reg <= 1'b0;
                        i_reg     <= FW'(1);
                        k_reg     <= '0;
                        if (!rep_reg && pos_reg < PW'(TEXT_MAX)) begin
                            if (pos_reg == '0 && n_cur > NW'(1)) begin
                                state_reg <= ST_BUILD;
                            end else begin
                                state_reg <= ST_MATCH;
                            end
                            if (NW'(q_reg) >= n_cur) begin
                                q_reg <= '0;
                            end
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_BUILD: begin
                    if (k_reg != '0 && !eq_b) begin
                        k_reg <= tbl_rd;
                    end else begin
                        k_reg <= k_next;
                        i_reg <= FW'(i_inc);
                        if (i_inc >= n_cur) begin
                            state_reg <= ST_MATCH;
                        end
                    end
                end
                ST_MATCH: begin
                    if (q_reg != '0 && !eq_m) begin
                        q_reg <= tbl_rd;
                    end else begin
                        pos_reg   <= pos_reg + PW'(1);
                        state_reg <= ST_FINISH;
                        if (q_next >= n_cur) begin
                            found_reg <= 1'b1;
                            start_reg <= start_full[MATCH_START_W-1:0];
                            rep_reg   <= 1'b1;
                            q_reg     <= '0;
                        end else begin
                            q_reg <= FW'(q_next);
                        end
                    end
                end
                ST_FINISH: begin
                    if (!(pend && out_busy)) begin
                        if (pend) begin
                            m_valid_reg <= 1'b1;
                            m_found_reg <= found_reg;
                            m_start_reg <= found_reg ? start_reg : '0;
                        end
                        if (last_reg) begin
                            pos_reg <= '0;
                            q_reg   <= '0;
                            rep_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                    CFG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                    CFG_PATTERN_LENGTH: plen_reg     <= cfg_wdata[PLEN_W-1:0];
                    default: begin
                    end
                endcase
                // the user is to make writes land between words; the block itself does not enforce it
                if (state_reg == ST_IDLE && !accept && NW'(q_reg) >= n_new) begin
                    q_reg <= '0;
                end
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-MATCH_START_W){1'b0}}, m_start_reg};
    assign m_tuser  = m_found_reg;

endmodule

### src/kfm_checker.sv
// Port-level checker for the KMP first-match finder, bound to the top level.
// Depends on kfm_pkg and kmp_first_match_finder_macros.svh.
`include "kmp_first_match_finder_macros.svh"

module kfm_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kfm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                    m_tuser
);
    import kfm_pkg::*;

    `KFM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
    `KFM_ASSERT_NOW(a_not_found_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "not-found word with nonzero start")
    `KFM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input ready right after accepting a word")
    `KFM_ASSERT_ALWAYS(a_reset_state, !aresetn, !m_tvalid && s_tready, "wrong port state after reset")

endmodule

bind kmp_first_match_finder kfm_checker u_kfm_checker (.*);
